// ===== rtl/core/hh4_pkg.sv =====
// hh4_pkg: shared types and constants for the HCI H4 receive deframer.
// No dependencies; imported by every module in rtl/core except hh4_in_reg.
package hh4_pkg;

	// Default for the largest total packet length (header plus payload).
	localparam int unsigned MaxPacketBytes = 254;

	// Packet length register width: a 16-bit ACL length plus a 4-byte header.
	localparam int unsigned LEN_W = 17;

	localparam logic [7:0] IND_ACL  = 8'd2;
	localparam logic [7:0] IND_EVT  = 8'd4;
	localparam logic [7:0] LOW_MASK = 8'd255;

	localparam logic [LEN_W-1:0] EVT_HDR     = LEN_W'(2);
	localparam logic [LEN_W-1:0] ACL_HDR     = LEN_W'(4);
	// ACL header byte that carries the low length byte
	localparam logic [LEN_W-1:0] ACL_LEN_LO  = LEN_W'(3);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_EVT  = 2'd1,
		PH_ACL  = 2'd2
	} hh4_phase_t;

	typedef enum logic [1:0] {
		KIND_IND = 2'd0,
		KIND_EVT = 2'd1,
		KIND_ACL = 2'd2
	} hh4_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNSUP    = 2'd1,
		ST_OVERSIZE = 2'd2
	} hh4_status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		hh4_kind_t   byte_kind;
		logic [7:0]  byte_position;
		logic        packet_last;
		hh4_status_t rx_status;
	} hh4_result_t;

endpackage

// ===== rtl/core/hci_h4_uart_receive_deframer.sv =====
// Channel   Dir  tdata                          tuser                    tlast
// s_*       in   [7:0] rx_byte                  -                        -
// m_*       out  [7:0] data_byte, [15:8] pos    [1:0] kind, [3:2] status packet_last
//
// One result request leaves for every byte request taken; one byte per cycle sustained while m_tready stays high.
// Each byte passes two register stages: input register, then tagging logic into the result register.
// The phase/count/length registers update only when a byte moves into the result register.
// Reset (arst_n low) empties both stages and returns the framer to idle.
// A stall on m_tready holds the result and the byte behind it, then backs up s_tready.
//
// Top level of the HCI H4 receive deframer; depends on hh4_pkg, hh4_in_reg,
// hh4_framer and hh4_out_reg.
module hci_h4_uart_receive_deframer #(
	parameter int unsigned MAX_PACKET_BYTES = hh4_pkg::MaxPacketBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [15:8] byte_position
	output logic [3:0]  m_tuser,   // [1:0] byte_kind, [3:2] rx_status
	output logic        m_tlast    // packet_last
);
	import hh4_pkg::*;

	// Byte counter never exceeds the largest accepted packet length.
	localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

	logic        valid_s1, take, advance;
	logic [7:0]  byte_s1;
	hh4_result_t result;

	// A byte advances when it is held and the result register can accept it.
	assign advance = valid_s1 && take;

	hh4_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Framing state lives here; decode is a short compare/add path.
	hh4_framer #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES),
		.CNT_W            (CNT_W)
	) u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	hh4_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s1),
		.result   (result),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/core/hh4_in_reg.sv =====
// hh4_in_reg: input register stage for received UART bytes.
// Depends on nothing but the clock and reset.
module hh4_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	// Refill in the same cycle the held byte moves on.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// ===== rtl/core/hh4_framer.sv =====
// hh4_framer: H4 packet phase tracking and per-byte tagging.
// Depends on hh4_pkg.
module hh4_framer #(
	parameter int unsigned MAX_PACKET_BYTES = hh4_pkg::MaxPacketBytes,
	parameter int unsigned CNT_W            = $clog2(MAX_PACKET_BYTES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          rx_byte,
	output hh4_pkg::hh4_result_t result
);
	import hh4_pkg::*;

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PACKET_BYTES);

	hh4_phase_t        phase_q, phase_d;
	logic [CNT_W-1:0]  count_q, count_d, cnt_inc;
	logic [LEN_W-1:0]  length_q, length_d, len_new;
	logic [LEN_W-1:0]  cnt_ext, cnt_old_ext, hdr_len;
	logic              is_evt, is_acl, hdr_end, oversize, complete;

	assign is_evt      = (phase_q == PH_EVT);
	assign is_acl      = (phase_q == PH_ACL);
	assign cnt_inc     = count_q + 1'b1;
	assign cnt_ext     = LEN_W'(cnt_inc);
	assign cnt_old_ext = LEN_W'(count_q);
	assign hdr_len     = is_evt ? EVT_HDR : ACL_HDR;

	// Length capture from the header bytes
	always_comb begin
		len_new = length_q;
		if (is_evt && cnt_ext == EVT_HDR) begin
			len_new = LEN_W'(rx_byte) + EVT_HDR;
		end else if (is_acl && cnt_ext == ACL_LEN_LO) begin
			len_new = LEN_W'(rx_byte);
		end else if (is_acl && cnt_ext == ACL_HDR) begin
			len_new = {1'b0, rx_byte, length_q[7:0] & LOW_MASK} + ACL_HDR;
		end
	end

	assign hdr_end  = (cnt_ext == hdr_len);
	assign oversize = hdr_end && (len_new > MaxLen);
	assign complete = (cnt_ext >= hdr_len) && (cnt_ext == len_new);

	// Next state
	always_comb begin
		phase_d  = PH_IDLE;
		count_d  = count_q;
		length_d = length_q;
		unique case (phase_q)
			PH_EVT, PH_ACL: begin
				count_d  = cnt_inc;
				length_d = len_new;
				phase_d  = (oversize || complete) ? PH_IDLE : phase_q;
			end
			default: begin
				if (rx_byte == IND_EVT || rx_byte == IND_ACL) begin
					phase_d  = (rx_byte == IND_EVT) ? PH_EVT : PH_ACL;
					count_d  = '0;
					length_d = '0;
				end
			end
		endcase
	end

	// Result tagging
	always_comb begin
		result.data_byte     = rx_byte;
		result.byte_kind     = KIND_IND;
		result.byte_position = '0;
		result.packet_last   = 1'b0;
		result.rx_status     = ST_OK;
		unique case (phase_q)
			PH_EVT, PH_ACL: begin
				result.byte_kind     = is_evt ? KIND_EVT : KIND_ACL;
				result.byte_position = cnt_old_ext[7:0];
				result.packet_last   = oversize || complete;
				result.rx_status     = oversize ? ST_OVERSIZE : ST_OK;
			end
			default: begin
				if (rx_byte != IND_EVT && rx_byte != IND_ACL) begin
					result.rx_status = ST_UNSUP;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			length_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			length_q <= length_d;
		end
	end

endmodule

// ===== rtl/core/hh4_out_reg.sv =====
// hh4_out_reg: result register driving the master-side stream.
// Depends on hh4_pkg.
module hh4_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	input  hh4_pkg::hh4_result_t result,
	output logic                 take,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,
	output logic [3:0]           m_tuser,
	output logic                 m_tlast
);
	import hh4_pkg::*;

	hh4_result_t res_q;

	assign take = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_in) begin
			res_q <= result;
		end
	end

	assign m_tdata = {res_q.byte_position, res_q.data_byte};
	assign m_tuser = {res_q.rx_status, res_q.byte_kind};
	assign m_tlast = res_q.packet_last;

endmodule

// ===== rtl/core/hh4_checker.sv =====
// hh4_checker: port-level assertions for the HCI H4 receive deframer.
// Depends on hh4_pkg; bound to hci_h4_uart_receive_deframer below.
module hh4_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);
	import hh4_pkg::*;

	// Stalled result request holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Indicator bytes sit at position zero and never close a packet.
	a_ind_tag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_IND |-> !m_tlast && m_tdata[15:8] == 8'd0)
		else $error("indicator byte mistagged");

	// Unsupported indicator is only reported on indicator bytes.
	a_unsup_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:2] == ST_UNSUP |-> m_tuser[1:0] == KIND_IND)
		else $error("unsupported status on packet byte");

	// Oversize drop always ends the packet.
	a_oversize_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:2] == ST_OVERSIZE |-> m_tlast && m_tuser[1:0] != KIND_IND)
		else $error("oversize drop without packet end");

endmodule

bind hci_h4_uart_receive_deframer hh4_checker u_hh4_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== verif/hci_h4_uart_receive_deframer_tb.sv =====
// Self-checking testbench for hci_h4_uart_receive_deframer: drives H4 byte streams with
// random gaps and output stalls, and predicts every tagged byte request in a scoreboard.
// Depends on hh4_pkg and the deframer RTL.
module hci_h4_uart_receive_deframer_tb;
	import hh4_pkg::*;

	localparam int unsigned EVT_HEADER_BYTES = 2;
	localparam int unsigned ACL_HEADER_BYTES = 4;
	localparam int unsigned ACL_LEN_LO_BYTE  = 3;
	// largest payload length that still fits MaxPacketBytes
	localparam int unsigned EVT_MAX_PAYLOAD  = MaxPacketBytes - EVT_HEADER_BYTES;
	localparam int unsigned ACL_MAX_PAYLOAD  = MaxPacketBytes - ACL_HEADER_BYTES;
	localparam int unsigned RANDOM_BYTES     = 1700;
	localparam int unsigned HOLD_OFF_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES     = 10;
	// no request moves on either side for this long: the block is hung
	localparam int unsigned STUCK_LIMIT      = 3000;
	localparam int unsigned MAX_REPORTS      = 10;

	// Scoreboard: keeps its own copy of the framer state, turns each accepted
	// byte into the tagged result it must produce and checks results in order.
	class h4_frame_scoreboard;
		hh4_phase_t     phase;
		int unsigned    byte_cnt;
		logic [16:0]    total_len;
		hh4_result_t    pending_q[$];
		int unsigned    mismatches;
		int unsigned    checked;
		int unsigned    packets_done;
		int unsigned    oversize_drops;
		int unsigned    unsupported;

		function new();
			phase          = PH_IDLE;
			byte_cnt       = 0;
			total_len      = '0;
			mismatches     = 0;
			checked        = 0;
			packets_done   = 0;
			oversize_drops = 0;
			unsupported    = 0;
		endfunction

		function int unsigned pending();
			return pending_q.size();
		endfunction

		// Tag one accepted byte and advance the framer state.
		function void note_byte(logic [7:0] b);
			hh4_result_t r;
			int unsigned hdr_bytes;
			r.data_byte     = b;
			r.byte_kind     = KIND_IND;
			r.byte_position = 8'd0;
			r.packet_last   = 1'b0;
			r.rx_status     = ST_OK;
			if (phase == PH_EVT || phase == PH_ACL) begin
				hdr_bytes       = (phase == PH_EVT) ? EVT_HEADER_BYTES : ACL_HEADER_BYTES;
				r.byte_kind     = (phase == PH_EVT) ? KIND_EVT : KIND_ACL;
				r.byte_position = byte_cnt[7:0];
				byte_cnt++;
				if (phase == PH_EVT) begin
					// second header byte is the parameter length
					if (byte_cnt == EVT_HEADER_BYTES)
						total_len = 17'(b) + 17'(EVT_HEADER_BYTES);
				end else begin
					// little-endian 16-bit length, low byte parked until the high one arrives
					if (byte_cnt == ACL_LEN_LO_BYTE)
						total_len = 17'(b);
					else if (byte_cnt == ACL_HEADER_BYTES)
						total_len = 17'({b, total_len[7:0]}) + 17'(ACL_HEADER_BYTES);
				end
				if (byte_cnt == hdr_bytes && total_len > 17'(MaxPacketBytes)) begin
					r.rx_status   = ST_OVERSIZE;
					r.packet_last = 1'b1;
					phase         = PH_IDLE;
					oversize_drops++;
				end else if (byte_cnt >= hdr_bytes && byte_cnt == total_len) begin
					r.packet_last = 1'b1;
					phase         = PH_IDLE;
					packets_done++;
				end
			end else begin
				phase = PH_IDLE;
				if (b == IND_EVT || b == IND_ACL) begin
					phase     = (b == IND_EVT) ? PH_EVT : PH_ACL;
					byte_cnt  = 0;
					total_len = '0;
				end else begin
					r.rx_status = ST_UNSUP;
					unsupported++;
				end
			end
			pending_q.push_back(r);
		endfunction

		// Compare one result request with the oldest prediction.
		function void check_result(logic [7:0] data, logic [1:0] kind, logic [7:0] pos,
				logic last, logic [1:0] status);
			hh4_result_t e;
			checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR %0t: unexpected result data=%02h kind=%0d pos=%0d last=%0b st=%0d",
						$time, data, kind, pos, last, status);
				return;
			end
			e = pending_q.pop_front();
			if (data !== e.data_byte || kind !== e.byte_kind || pos !== e.byte_position ||
					last !== e.packet_last || status !== e.rx_status) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("ERROR %0t: result %0d exp data=%02h kind=%0d pos=%0d last=%0b st=%0d",
						$time, checked, e.data_byte, e.byte_kind, e.byte_position,
						e.packet_last, e.rx_status);
					$display("      got data=%02h kind=%0d pos=%0d last=%0b st=%0d",
						data, kind, pos, last, status);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] data_byte, [15:8] byte_position
	logic [3:0]  m_tuser;   // [1:0] byte_kind, [3:2] rx_status
	logic        m_tlast;   // packet_last

	h4_frame_scoreboard sb = new();

	int unsigned bytes_sent;
	int unsigned burst_left;
	int unsigned stuck_cycles;
	bit          hold_req;   // stimulus asks the receiver for one long hold-off
	bit          hold_done;

	hci_h4_uart_receive_deframer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Monitor: both handshakes sampled at the rising edge, before any NBA lands.
	// Inputs are noted first; a byte passes the input and result registers before
	// it shows as an output, so an output never belongs to the byte taken at the same edge anyway.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[7:0], m_tuser[1:0], m_tdata[15:8], m_tlast,
					m_tuser[3:2]);
		end
	end

	// Watchdog: any request moving on either side counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
			$display("ERROR: no request moved for %0d cycles, %0d results still due",
				STUCK_LIMIT, sb.pending());
			$display("** hci_h4_uart_receive_deframer: FAILED **");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Receiver: switches between always-ready, random and periodic stall
	// patterns for random spans; once asked, holds m_tready low long enough to
	// fill both stages and push back on s_tready.
	initial begin
		int unsigned mode;
		int unsigned span_left;
		int unsigned phase_cnt;
		m_tready  <= 1'b0;
		hold_done  = 1'b0;
		span_left  = 0;
		mode       = 0;
		phase_cnt  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else begin
				if (span_left == 0) begin
					mode      = $urandom_range(0, 3);
					span_left = $urandom_range(8, 120);
				end
				span_left--;
				phase_cnt++;
				case (mode)
					0: begin
						m_tready <= 1'b1;
					end
					1: begin
						m_tready <= ($urandom_range(0, 99) < 60);
					end
					2: begin
						// ready only when phase_cnt is a multiple of three
						m_tready <= (phase_cnt % 3 == 0);
					end
					default: begin
						m_tready <= ($urandom_range(0, 99) < 90);
					end
				endcase
			end
		end
	end

	// Offer one byte; the sender works in bursts with random gaps between them.
	// s_tready is read at the falling edge, where it holds its value for the
	// coming rising edge.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		logic        rdy;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		burst_left--;
		bytes_sent++;
	endtask

	// Event packet: indicator, event code, length, then n_payload bytes.
	task automatic send_event(input logic [7:0] len, input int unsigned n_payload);
		send_byte(IND_EVT);
		send_byte(8'($urandom));
		send_byte(len);
		repeat (n_payload) send_byte(8'($urandom));
	endtask

	// ACL packet: indicator, two handle bytes, 16-bit length low first, payload.
	task automatic send_acl(input logic [15:0] len, input int unsigned n_payload);
		send_byte(IND_ACL);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		repeat (n_payload) send_byte(8'($urandom));
	endtask

	// Idle the sender until every result is back.
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
	endtask

	initial begin
		int unsigned pick;
		int unsigned len;
		s_tvalid   <= 1'b0;
		s_tdata    <= 8'd0;
		arst_n     <= 1'b0;
		hold_req    = 1'b0;
		bytes_sent  = 0;
		burst_left  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unsupported indicators at both ends of the byte range,
		// empty payloads, and oversize lengths on both packet types.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h03);
		send_event(8'd0, 0);
		send_acl(16'd0, 0);
		send_event(8'(EVT_MAX_PAYLOAD + 1), 0);
		send_acl(16'(ACL_MAX_PAYLOAD + 1), 0);
		send_acl(16'hFFFF, 0);

		// Random: mostly well-formed packets with random content, a few at the
		// largest legal size, some oversize headers, noise and cut-off packets.
		while (bytes_sent < RANDOM_BYTES) begin
			if (!hold_req && bytes_sent > 600)
				hold_req = 1'b1;
			if (bytes_sent > 1200 && bytes_sent < 1260)
				wait_all_results();
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				case ($urandom_range(0, 19))
					0: begin
						send_event(8'(EVT_MAX_PAYLOAD), EVT_MAX_PAYLOAD);
					end
					1: begin
						send_event(8'($urandom_range(EVT_MAX_PAYLOAD + 1, 255)), 0);
					end
					default: begin
						len = $urandom_range(0, 16);
						send_event(8'(len), len);
					end
				endcase
			end else if (pick < 85) begin
				case ($urandom_range(0, 19))
					0: begin
						send_acl(16'(ACL_MAX_PAYLOAD), ACL_MAX_PAYLOAD);
					end
					1: begin
						send_acl(16'($urandom_range(ACL_MAX_PAYLOAD + 1, 65535)), 0);
					end
					default: begin
						len = $urandom_range(0, 16);
						send_acl(16'(len), len);
					end
				endcase
			end else if (pick < 93) begin
				send_byte(8'($urandom));
			end else begin
				// a packet cut short: indicator and a few stray bytes
				send_byte(($urandom_range(0, 1) == 0) ? IND_EVT : IND_ACL);
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.mismatches++;

		$display("Run covered %0d byte requests, %0d results checked: %0d packets completed,",
			bytes_sent, sb.checked, sb.packets_done);
		$display("%0d oversize drops, %0d unsupported indicators, %0d mismatches.",
			sb.oversize_drops, sb.unsupported, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("** hci_h4_uart_receive_deframer: PASSED **");
		end else begin
			$display("** hci_h4_uart_receive_deframer: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/hh4_pkg.sv
rtl/core/hh4_in_reg.sv
rtl/core/hh4_framer.sv
rtl/core/hh4_out_reg.sv
rtl/core/hci_h4_uart_receive_deframer.sv
rtl/core/hh4_checker.sv
verif/hci_h4_uart_receive_deframer_tb.sv
